// ===== src/xsd_pkg.sv =====
// ----------------------------------------------------------------------------
// xsd_pkg
// Types and constants for the x-direction three-point stencil unit.
// ----------------------------------------------------------------------------
package xsd_pkg;

  localparam int DATA_W  = 32;   // sample, weight and result width (Q16.16)
  localparam int ROW_W   = 10;   // width of the row index in a result
  localparam int COL_W   = 10;   // width of the column index in a result
  localparam int CFG_W   = 11;   // width of the count registers
  localparam int PROD_W  = 2 * DATA_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int FRAC_W  = 16;

  // register indexes on the configuration port
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = 66'sd32768;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // operands of one stencil evaluation
  typedef struct packed {
    logic signed [DATA_W-1:0] wl;
    logic signed [DATA_W-1:0] vl;
    logic signed [DATA_W-1:0] wd;
    logic signed [DATA_W-1:0] vd;
    logic signed [DATA_W-1:0] wu;
    logic signed [DATA_W-1:0] vu;
  } ops_t;

  // position tag that travels with a result
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_end;
  } tag_t;

endpackage

// ===== src/xsd_ram.sv =====
// ----------------------------------------------------------------------------
// xsd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module xsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // a read of the address being written returns the old contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/x_stencil_derivative_with_boundary_unit.sv =====
// ----------------------------------------------------------------------------
// x_stencil_derivative_with_boundary_unit
// Three-point x-direction stencil over a streamed grid, two line buffers in
// RAM, row 0 extrapolated, last row closed with a zero neighbor, Q16.16.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  cfg_     in   cfg_valid/ready    cfg_index: 0 row_count, 1 column_count
//  in_      in   in_tvalid/tready   tdata: sample, coef_low, coef_diag, coef_up
//  out_     out  out_tvalid/tready  tdata: derivative, out_row, out_column;
//                                   tlast: frame_end
//
//  one item per cycle when the output does not stall; an item of the last row
//  gives two results and holds the read stage for both, since both share one
//  set of multipliers. each result passes the operand, product, sum and output registers.
//  rst_n is synchronous; the line buffers need no clearing pass.
//  out_tready low stalls the pipeline, and in_tready follows it.
//  any register write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module x_stencil_derivative_with_boundary_unit #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [10:0]  cfg_data,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // sample, coef_low, coef_diag, coef_up
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,  // derivative, out_row, out_column, 4'b0
  output logic         out_tlast   // frame_end
);

  localparam int DW   = xsd_pkg::DATA_W;
  localparam int CFW  = xsd_pkg::CFG_W;
  localparam int RW   = xsd_pkg::ROW_W;
  localparam int CLW  = xsd_pkg::COL_W;
  localparam int PRW  = xsd_pkg::PROD_W;
  localparam int SMW  = xsd_pkg::SUM_W;
  localparam int FW   = xsd_pkg::FRAC_W;
  localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int PW   = (CW > CFW) ? CW : CFW;
  localparam int QW   = SMW - FW;
  localparam logic [16:0] MAXR = 17'(MAX_ROWS);
  localparam logic [16:0] MAXC = 17'(MAX_COLUMNS);

  // ---------------------------------------------------------------- config
  logic [CFW-1:0] row_count_r;
  logic [CFW-1:0] col_count_r;
  logic [CFW-1:0] rows_eff;
  logic [CFW-1:0] cols_eff;
  logic [CFW-1:0] row_last;
  logic [CFW-1:0] col_last;
  logic           cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= xsd_pkg::COUNT_RESET;
      col_count_r <= xsd_pkg::COUNT_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        xsd_pkg::REG_ROW_COUNT:    row_count_r <= cfg_data;
        xsd_pkg::REG_COLUMN_COUNT: col_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_count_r < 11'd2) begin
      rows_eff = 11'd2;
    end else if (17'(row_count_r) > MAXR) begin
      rows_eff = CFW'(MAXR);
    end else begin
      rows_eff = row_count_r;
    end
    if (col_count_r == '0) begin
      cols_eff = 11'd1;
    end else if (17'(col_count_r) > MAXC) begin
      cols_eff = CFW'(MAXC);
    end else begin
      cols_eff = col_count_r;
    end
  end

  assign row_last = rows_eff - 11'd1;
  assign col_last = cols_eff - 11'd1;

  // ---------------------------------------------------------------- input side
  logic signed [DW-1:0] in_sample;
  logic signed [DW-1:0] in_coef_low;
  logic signed [DW-1:0] in_coef_diag;
  logic signed [DW-1:0] in_coef_up;

  assign in_sample    = in_tdata[31:0];
  assign in_coef_low  = in_tdata[63:32];
  assign in_coef_diag = in_tdata[95:64];
  assign in_coef_up   = in_tdata[127:96];

  logic [CFW-1:0] row_pos_r;
  logic [CW-1:0]  col_pos_r;
  logic           at_last_row;
  logic           at_last_col;
  logic           in_fire;

  logic signed [DW-1:0] prev_low_r, prev_diag_r, prev_up_r;
  logic signed [DW-1:0] cur_low_r, cur_diag_r, cur_up_r;

  assign at_last_row = (row_pos_r == row_last);
  assign at_last_col = (PW'(col_pos_r) == PW'(col_last));
  assign in_fire     = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      prev_low_r  <= '0;
      prev_diag_r <= '0;
      prev_up_r   <= '0;
      cur_low_r   <= '0;
      cur_diag_r  <= '0;
      cur_up_r    <= '0;
    end else if (cfg_fire) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
    end else if (in_fire) begin
      if (at_last_col) begin
        col_pos_r <= '0;
        row_pos_r <= at_last_row ? '0 : row_pos_r + 11'd1;
      end else begin
        col_pos_r <= col_pos_r + CW'(1);
      end
      // weights are taken at the first column of each row
      if (col_pos_r == '0) begin
        prev_low_r  <= cur_low_r;
        prev_diag_r <= cur_diag_r;
        prev_up_r   <= cur_up_r;
        cur_low_r   <= in_coef_low;
        cur_diag_r  <= in_coef_diag;
        cur_up_r    <= in_coef_up;
      end
    end
  end

  // ---------------------------------------------------------------- line buffers
  logic          ram_we;
  logic [DW-1:0] older_rd;
  logic [DW-1:0] recent_rd;
  logic signed [DW-1:0] cur_m;
  logic signed [DW-1:0] cur_o;

  logic                 v1_r;
  logic                 phase_r;
  logic signed [DW-1:0] s1_sample_r;
  logic [CFW-1:0]       s1_row_r;
  logic [CW-1:0]        s1_col_r;
  logic                 s1_last_row_r;
  logic                 s1_last_col_r;

  xsd_ram #(.WIDTH(DW), .DEPTH(MAX_COLUMNS)) u_older_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_col_r),
    .wr_data (cur_m),
    .rd_en   (in_fire),
    .rd_addr (col_pos_r),
    .rd_data (older_rd)
  );

  xsd_ram #(.WIDTH(DW), .DEPTH(MAX_COLUMNS)) u_recent_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (s1_col_r),
    .wr_data (s1_sample_r),
    .rd_en   (in_fire),
    .rd_addr (col_pos_r),
    .rd_data (recent_rd)
  );

  // a read that meets the write of the same column takes the written data
  logic                 fwd_r;
  logic signed [DW-1:0] fwd_recent_r;
  logic signed [DW-1:0] fwd_older_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (in_fire) begin
      fwd_r <= ram_we && (s1_col_r == col_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_recent_r <= s1_sample_r;
      fwd_older_r  <= cur_m;
    end
  end

  assign cur_m = fwd_r ? fwd_recent_r : recent_rd;
  assign cur_o = fwd_r ? fwd_older_r  : older_rd;

  // ---------------------------------------------------------------- read stage
  logic s2_free, s3_free, s4_free, o_free;
  logic has_a, has_b, use_a, emit, last_job, s1_done;

  logic signed [DW+1:0] extrap_wide;
  logic signed [DW-1:0] extrap;
  xsd_pkg::ops_t        ops_nxt;
  xsd_pkg::tag_t        tag_nxt;

  assign has_a    = (s1_row_r != '0);
  assign has_b    = s1_last_row_r;
  assign last_job = !(has_a && has_b) || phase_r;
  assign emit     = v1_r && (has_a || has_b) && s2_free;
  assign s1_done  = v1_r && (!(has_a || has_b) || (s2_free && last_job));
  assign use_a    = has_a && !phase_r;
  assign ram_we   = s1_done;
  assign in_tready = !v1_r || s1_done;

  // row 0 neighbor below the grid: 2*v0 - v1, saturated
  assign extrap_wide = ((DW+2)'(cur_m) <<< 1) - (DW+2)'(s1_sample_r);

  always_comb begin
    if (extrap_wide[DW+1:DW-1] == 3'b000 || extrap_wide[DW+1:DW-1] == 3'b111) begin
      extrap = extrap_wide[DW-1:0];
    end else if (extrap_wide[DW+1]) begin
      extrap = xsd_pkg::SAT_MIN;
    end else begin
      extrap = xsd_pkg::SAT_MAX;
    end
  end

  always_comb begin
    if (use_a) begin
      ops_nxt.wl        = prev_low_r;
      ops_nxt.vl        = (s1_row_r == 11'd1) ? extrap : cur_o;
      ops_nxt.wd        = prev_diag_r;
      ops_nxt.vd        = cur_m;
      ops_nxt.wu        = prev_up_r;
      ops_nxt.vu        = s1_sample_r;
      tag_nxt.row       = RW'(s1_row_r - 11'd1);
      tag_nxt.frame_end = 1'b0;
    end else begin
      ops_nxt.wl        = cur_low_r;
      ops_nxt.vl        = cur_m;
      ops_nxt.wd        = cur_diag_r;
      ops_nxt.vd        = s1_sample_r;
      ops_nxt.wu        = '0;
      ops_nxt.vu        = '0;
      tag_nxt.row       = RW'(s1_row_r);
      tag_nxt.frame_end = s1_last_col_r;
    end
    tag_nxt.col = CLW'(s1_col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (in_tready) begin
        v1_r <= in_tvalid;
      end
      if (s1_done) begin
        phase_r <= 1'b0;
      end else if (emit) begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r   <= in_sample;
      s1_row_r      <= row_pos_r;
      s1_col_r      <= col_pos_r;
      s1_last_row_r <= at_last_row;
      s1_last_col_r <= at_last_col;
    end
  end

  // ---------------------------------------------------------------- arithmetic
  logic                  v2_r, v3_r, v4_r, vo_r;
  xsd_pkg::ops_t         ops2_r;
  xsd_pkg::tag_t         tag2_r, tag3_r, tag4_r, tago_r;
  logic signed [PRW-1:0] prod_l_r, prod_d_r, prod_u_r;
  logic signed [SMW-1:0] sum_r;
  logic signed [SMW-1:0] sum_nxt;
  logic signed [QW-1:0]  quot;
  logic signed [DW-1:0]  deriv_nxt;
  logic signed [DW-1:0]  deriv_r;

  assign o_free  = !vo_r || out_tready;
  assign s4_free = !v4_r || o_free;
  assign s3_free = !v3_r || s4_free;
  assign s2_free = !v2_r || s3_free;

  // exact Q32.32 sum, then round half up back to Q16.16
  assign sum_nxt = SMW'(prod_l_r) + SMW'(prod_d_r) + SMW'(prod_u_r)
                   + xsd_pkg::ROUND_HALF;
  assign quot    = sum_r[SMW-1:FW];

  always_comb begin
    if (quot[QW-1:DW-1] == '0 || quot[QW-1:DW-1] == '1) begin
      deriv_nxt = quot[DW-1:0];
    end else if (quot[QW-1]) begin
      deriv_nxt = xsd_pkg::SAT_MIN;
    end else begin
      deriv_nxt = xsd_pkg::SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (s2_free) begin
        v2_r <= emit;
      end
      if (s3_free) begin
        v3_r <= v2_r;
      end
      if (s4_free) begin
        v4_r <= v3_r;
      end
      if (o_free) begin
        vo_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      ops2_r <= ops_nxt;
      tag2_r <= tag_nxt;
    end
    if (s3_free) begin
      prod_l_r <= PRW'(ops2_r.wl) * PRW'(ops2_r.vl);
      prod_d_r <= PRW'(ops2_r.wd) * PRW'(ops2_r.vd);
      prod_u_r <= PRW'(ops2_r.wu) * PRW'(ops2_r.vu);
      tag3_r   <= tag2_r;
    end
    if (s4_free) begin
      sum_r  <= sum_nxt;
      tag4_r <= tag3_r;
    end
    if (o_free) begin
      deriv_r <= deriv_nxt;
      tago_r  <= tag4_r;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {4'b0000, tago_r.col, tago_r.row, deriv_r};
  assign out_tlast  = tago_r.frame_end;

  // ---------------------------------------------------------------- checks
  a_phase_only_on_two_jobs: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && phase_r) |-> (has_a && has_b))
    else $error("second job phase set on an item with fewer than two results");

  a_read_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !s1_done) |=> ($stable(recent_rd) && $stable(older_rd)))
    else $error("line buffer read data changed under a held item");

  a_frame_end_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tdata[41:32] == RW'(row_last) && out_tdata[51:42] == CLW'(col_last)))
    else $error("frame end flagged away from the last row and column");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && phase_r && !s2_free) |-> !in_tready)
    else $error("input accepted while a two-result item is still pending");

endmodule
